// ----- rtl/u8map_pkg.sv -----
// Shared constants, types and codes for the UTF-8 to charset byte mapper.
package u8map_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    // load index compare width, wide enough to hold TABLE_ENTRIES itself
    localparam int EXT_W = ((IDX_W > 8) ? IDX_W : 8) + 1;

    localparam int CP_W      = 21;
    localparam int BYTE_W    = 8;
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;

    localparam logic [1:0] OP_TEXT = 2'd0;
    localparam logic [1:0] OP_LOAD = 2'd1;
    localparam logic [1:0] OP_EOL  = 2'd2;

    localparam logic [BYTE_W-1:0] REPL_RESET = 8'h3F;

    typedef struct packed {
        logic              used;
        logic [CP_W-1:0]   cp;
        logic [BYTE_W-1:0] data;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

endpackage

// ----- rtl/u8map_ram.sv -----
// Generic simple dual-port RAM, one write port, one registered read port.
module u8map_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/utf8_to_charset_byte_mapper_core.sv -----
// Top level: UTF-8 decoder with code point to charset byte table lookup.
//
// After reset the block sweeps the table memory, one slot per cycle, and takes
// no input word meanwhile (config writes are taken). A load word, a text byte
// that does not complete a code point, or opcode 3 leaves the block idle and
// ready for the next word; an end of line passes through the emit state. A
// completed code point scans the table memory from slot 0, one read per cycle
// through its single read port: the lowest used slot with a matching key ends
// the scan as a hit, else it ends as a miss after the last slot. The next word
// is taken once the result has moved to the output register, even while that register waits on m_tready.
module utf8_to_charset_byte_mapper_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // text_byte[7:0], entry_index[15:8], entry_codepoint[36:16],
    // entry_byte[44:37], entry_valid[45], zero fill
    input  logic [u8map_pkg::S_TDATA_W-1:0] s_tdata,
    // opcode[1:0]
    input  logic [u8map_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_byte[7:0], decoded_codepoint[28:8], zero fill
    output logic [u8map_pkg::M_TDATA_W-1:0] m_tdata,
    // unmapped[0]
    output logic                            m_tuser,
    // end_of_line
    output logic                            m_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [u8map_pkg::BYTE_W-1:0]    cfg_data
);

    import u8map_pkg::*;

    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(TABLE_ENTRIES - 1);
    localparam logic [EXT_W-1:0] ENTRIES_EXT = EXT_W'(TABLE_ENTRIES);

    // input fields
    logic [1:0]        opcode;
    logic [7:0]        text_byte;
    logic [7:0]        entry_index;
    logic [CP_W-1:0]   entry_codepoint;
    logic [BYTE_W-1:0] entry_byte;
    logic              entry_valid;

    assign opcode          = s_tuser;
    assign text_byte       = s_tdata[7:0];
    assign entry_index     = s_tdata[15:8];
    assign entry_codepoint = s_tdata[36:16];
    assign entry_byte      = s_tdata[44:37];
    assign entry_valid     = s_tdata[45];

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               chk_valid_reg, chk_valid_next;
    logic               chk_last_reg, chk_last_next;
    logic [1:0]         pend_reg, pend_next;
    logic [CP_W-1:0]    part_reg, part_next;
    logic               broken_reg, broken_next;
    logic [BYTE_W-1:0]  repl_reg, repl_next;
    logic               out_valid_reg, out_valid_next;

    logic [BYTE_W-1:0]  res_byte_reg, res_byte_next;
    logic [CP_W-1:0]    res_cp_reg, res_cp_next;
    logic               res_unm_reg, res_unm_next;
    logic               res_eol_reg, res_eol_next;
    logic [BYTE_W-1:0]  out_byte_reg, out_byte_next;
    logic [CP_W-1:0]    out_cp_reg, out_cp_next;
    logic               out_unm_reg, out_unm_next;
    logic               out_eol_reg, out_eol_next;

    logic               in_acc;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    slot_t              ram_wslot;
    logic               ram_re;
    logic [SLOT_W-1:0]  ram_rdata;
    slot_t              rd_slot;
    logic [EXT_W-1:0]   ld_idx_ext;
    logic               ld_in_range;
    logic               hit;
    logic               issue_en;
    logic               bad_cont;
    logic [CP_W-1:0]    shifted_cp;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = s_tvalid && s_tready;

    assign ld_idx_ext  = EXT_W'(entry_index);
    assign ld_in_range = (ld_idx_ext < ENTRIES_EXT);

    assign rd_slot  = slot_t'(ram_rdata);
    assign hit      = rd_slot.used && (rd_slot.cp == res_cp_reg);
    assign issue_en = (state_reg == ST_SCAN) && (cnt_reg != CNT_W'(TABLE_ENTRIES));
    assign ram_re   = issue_en;

    assign bad_cont   = (text_byte[7:6] != 2'b10);
    assign shifted_cp = {part_reg[CP_W-7:0], text_byte[5:0]};

    u8map_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wslot),
        .re    (ram_re),
        .raddr (cnt_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        chk_valid_next = issue_en;
        chk_last_next  = issue_en && (cnt_reg == LAST_IDX);
        pend_next      = pend_reg;
        part_next      = part_reg;
        broken_next    = broken_reg;
        repl_next      = repl_reg;
        out_valid_next = out_valid_reg;
        res_byte_next  = res_byte_reg;
        res_cp_next    = res_cp_reg;
        res_unm_next   = res_unm_reg;
        res_eol_next   = res_eol_reg;
        out_byte_next  = out_byte_reg;
        out_cp_next    = out_cp_reg;
        out_unm_next   = out_unm_reg;
        out_eol_next   = out_eol_reg;
        ram_we         = 1'b0;
        ram_waddr      = cnt_reg[IDX_W-1:0];
        ram_wslot      = '0;

        if (cfg_valid)
        begin
            repl_next = cfg_data;
        end

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (opcode)
                        OP_TEXT:
                        begin
                            if (pend_reg != 2'd0)
                            begin
                                if (bad_cont)
                                begin
                                    broken_next = 1'b1;
                                end
                                else if (!broken_reg)
                                begin
                                    part_next = shifted_cp;
                                end
                                pend_next = pend_reg - 2'd1;
                                if (pend_reg == 2'd1)
                                begin
                                    broken_next = 1'b0;
                                    part_next   = '0;
                                    if (!broken_reg && !bad_cont)
                                    begin
                                        res_cp_next = shifted_cp;
                                        cnt_next    = '0;
                                        state_next  = ST_SCAN;
                                    end
                                end
                            end
                            else if (text_byte[7] == 1'b0)
                            begin
                                res_cp_next = CP_W'(text_byte);
                                cnt_next    = '0;
                                state_next  = ST_SCAN;
                            end
                            else if (text_byte[7:5] == 3'b110)
                            begin
                                part_next   = CP_W'(text_byte[4:0]);
                                pend_next   = 2'd1;
                                broken_next = 1'b0;
                            end
                            else if (text_byte[7:4] == 4'b1110)
                            begin
                                part_next   = CP_W'(text_byte[3:0]);
                                pend_next   = 2'd2;
                                broken_next = 1'b0;
                            end
                            else if (text_byte[7:3] == 5'b11110)
                            begin
                                part_next   = CP_W'(text_byte[2:0]);
                                pend_next   = 2'd3;
                                broken_next = 1'b0;
                            end
                        end

                        OP_LOAD:
                        begin
                            if (ld_in_range)
                            begin
                                ram_we         = 1'b1;
                                ram_waddr      = ld_idx_ext[IDX_W-1:0];
                                ram_wslot.used = entry_valid;
                                ram_wslot.cp   = entry_codepoint;
                                ram_wslot.data = entry_byte;
                            end
                        end

                        OP_EOL:
                        begin
                            pend_next     = 2'd0;
                            part_next     = '0;
                            broken_next   = 1'b0;
                            res_byte_next = '0;
                            res_cp_next   = '0;
                            res_unm_next  = 1'b0;
                            res_eol_next  = 1'b1;
                            state_next    = ST_EMIT;
                        end

                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (issue_en)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                // read data for an issued address arrives in the next cycle
                if (chk_valid_reg && hit)
                begin
                    res_byte_next = rd_slot.data;
                    res_unm_next  = 1'b0;
                    res_eol_next  = 1'b0;
                    state_next    = ST_EMIT;
                end
                else if (chk_valid_reg && chk_last_reg)
                begin
                    res_byte_next = repl_reg;
                    res_unm_next  = 1'b1;
                    res_eol_next  = 1'b0;
                    state_next    = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = res_byte_reg;
                    out_cp_next    = res_cp_reg;
                    out_unm_next   = res_unm_reg;
                    out_eol_next   = res_eol_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            chk_valid_reg <= 1'b0;
            chk_last_reg  <= 1'b0;
            pend_reg      <= 2'd0;
            part_reg      <= '0;
            broken_reg    <= 1'b0;
            repl_reg      <= REPL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            chk_valid_reg <= chk_valid_next;
            chk_last_reg  <= chk_last_next;
            pend_reg      <= pend_next;
            part_reg      <= part_next;
            broken_reg    <= broken_next;
            repl_reg      <= repl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_byte_reg <= res_byte_next;
        res_cp_reg   <= res_cp_next;
        res_unm_reg  <= res_unm_next;
        res_eol_reg  <= res_eol_next;
        out_byte_reg <= out_byte_next;
        out_cp_reg   <= out_cp_next;
        out_unm_reg  <= out_unm_next;
        out_eol_reg  <= out_eol_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - CP_W - BYTE_W){1'b0}}, out_cp_reg, out_byte_reg};
    assign m_tuser  = out_unm_reg;
    assign m_tlast  = out_eol_reg;

endmodule

// ----- rtl/u8map_checker.sv -----
// Port-level assertions for the mapper core, bound to the top level.
module u8map_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [u8map_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [u8map_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                            m_tuser,
    input logic                            m_tlast
);

    import u8map_pkg::*;

    // end marker carries no byte, no code point and no unmapped flag
    a_eol_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> ((m_tdata == '0) && !m_tuser))
        else $error("end marker word carries nonzero payload");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)
            && $stable(m_tuser) && $stable(m_tlast)))
        else $error("stalled output word changed");

    // an end of line always produces a result before the next word
    a_eol_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == OP_EOL)) |=> !s_tready)
        else $error("input taken right after end of line");

    // a table load never blocks the input
    a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == OP_LOAD)) |=> s_tready)
        else $error("input stalled after table load");

endmodule

bind utf8_to_charset_byte_mapper_core u8map_checker u_u8map_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ----- verif/utf8_to_charset_byte_mapper_core_tb.sv -----
// Self-checking testbench for the UTF-8 to charset byte mapper core.
module utf8_to_charset_byte_mapper_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import u8map_pkg::*;

    localparam logic [1:0] OP_NOP = 2'd3;
    localparam int WD_LIMIT      = 20000;
    localparam int HOLD_CYCLES   = 1500;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_WORDS   = 120;
    localparam int N_PHASES      = 5;
    localparam int POOL_MAX      = 48;
    localparam int N_DIR         = 26;

    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TYPED} chk_t;

    typedef struct packed {
        logic [BYTE_W-1:0] ch;
        logic [CP_W-1:0]   cp;
        logic              unmapped;
        logic              eol;
    } cs_out_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [7:0]        text;
        logic [7:0]        idx;
        logic [CP_W-1:0]   cp;
        logic [BYTE_W-1:0] ch;
        logic              vld;
        chk_t              chk;
        logic [BYTE_W-1:0] x_ch;
        logic [CP_W-1:0]   x_cp;
        logic              x_unm;
        logic              x_eol;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [BYTE_W-1:0]    cfg_data;

    // travels alongside the input word: how its result is checked
    chk_t    word_chk;
    cs_out_t word_typed;

    // predictor state
    logic [BYTE_W-1:0] repl_ch;
    logic [1:0]        pend_cnt;
    logic [CP_W-1:0]   part_cp;
    logic              seq_bad;
    logic              slot_used [TABLE_ENTRIES];
    logic [CP_W-1:0]   slot_cp   [TABLE_ENTRIES];
    logic [BYTE_W-1:0] slot_ch   [TABLE_ENTRIES];

    cs_out_t         charset_out_q[$];
    logic [CP_W-1:0] key_pool[$];
    dir_row_t        dir_tbl [N_DIR];

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    bit hold_req = 1'b0;
    int idle_cycles = 0;
    int n_errors = 0;
    int n_sent = 0;
    int n_hit = 0;
    int n_miss = 0;
    int n_eol = 0;
    int n_cfg = 0;

    always #1 clk = ~clk;

    utf8_to_charset_byte_mapper_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // first valid slot with a matching key wins
    function automatic cs_out_t lookup_cp(input logic [CP_W-1:0] cp);
        cs_out_t r;
        logic    found;
        r.ch = repl_ch;
        r.cp = cp;
        r.unmapped = 1'b1;
        r.eol = 1'b0;
        found = 1'b0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (!found && slot_used[i] && slot_cp[i] == cp)
            begin
                found = 1'b1;
                r.ch = slot_ch[i];
                r.unmapped = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic logic decode_map_word(input logic [1:0] op,
                                             input logic [S_TDATA_W-1:0] d,
                                             output cs_out_t r);
        logic [7:0]      b;
        logic [7:0]      idx;
        logic            bad;
        logic [CP_W-1:0] cp;
        logic            has;
        b = d[7:0];
        idx = d[15:8];
        has = 1'b0;
        r = '0;
        if (op == OP_TEXT)
        begin
            if (pend_cnt != 2'd0)
            begin
                // claimed byte: consumed even when it is not a continuation
                if (b[7:6] != 2'b10)
                    seq_bad = 1'b1;
                else if (!seq_bad)
                    part_cp = {part_cp[CP_W-7:0], b[5:0]};
                pend_cnt = pend_cnt - 2'd1;
                if (pend_cnt == 2'd0)
                begin
                    bad = seq_bad;
                    cp = part_cp;
                    seq_bad = 1'b0;
                    part_cp = '0;
                    if (!bad)
                    begin
                        r = lookup_cp(cp);
                        has = 1'b1;
                    end
                end
            end
            else if (!b[7])
            begin
                r = lookup_cp(CP_W'(b));
                has = 1'b1;
            end
            else if (b[7:5] == 3'b110)
            begin
                part_cp = CP_W'(b[4:0]);
                pend_cnt = 2'd1;
                seq_bad = 1'b0;
            end
            else if (b[7:4] == 4'b1110)
            begin
                part_cp = CP_W'(b[3:0]);
                pend_cnt = 2'd2;
                seq_bad = 1'b0;
            end
            else if (b[7:3] == 5'b11110)
            begin
                part_cp = CP_W'(b[2:0]);
                pend_cnt = 2'd3;
                seq_bad = 1'b0;
            end
            // stray continuation or 11111xxx lead: skipped
        end
        else if (op == OP_LOAD)
        begin
            if (int'(idx) < TABLE_ENTRIES)
            begin
                slot_cp[idx] = d[36:16];
                slot_ch[idx] = d[44:37];
                slot_used[idx] = d[45];
            end
        end
        else if (op == OP_EOL)
        begin
            pend_cnt = 2'd0;
            part_cp = '0;
            seq_bad = 1'b0;
            r.eol = 1'b1;
            has = 1'b1;
        end
        return has;
    endfunction

    function automatic logic [CP_W-1:0] rand_cp();
        logic [CP_W-1:0] cp;
        case ($urandom_range(3))
            0:       cp = CP_W'($urandom_range(32'h7F));
            1:       cp = CP_W'($urandom_range(32'h7FF));
            2:       cp = CP_W'($urandom_range(32'hFFFF));
            default: cp = CP_W'($urandom);
        endcase
        return cp;
    endfunction

    always @(posedge clk)
    begin
        cs_out_t got;
        cs_out_t want;
        cs_out_t pred;
        logic    has_out;
        logic    moved;
        if (rst_n)
        begin
            moved = 1'b0;
            // results first, so a word taken at this edge cannot hide a stray one
            if (m_tvalid && m_tready)
            begin
                moved = 1'b1;
                got.ch = m_tdata[7:0];
                got.cp = m_tdata[28:8];
                got.unmapped = m_tuser;
                got.eol = m_tlast;
                if (charset_out_q.size() == 0)
                begin
                    $display("%0t: unexpected word out: ch %02h cp %06h unmapped %0d eol %0d",
                             $time, got.ch, got.cp, got.unmapped, got.eol);
                    n_errors++;
                end
                else
                begin
                    want = charset_out_q.pop_front();
                    if (got.ch !== want.ch || got.cp !== want.cp ||
                        got.unmapped !== want.unmapped || got.eol !== want.eol)
                    begin
                        $display("%0t: mismatch: expected ch %02h cp %06h unmapped %0d eol %0d",
                                 $time, want.ch, want.cp, want.unmapped, want.eol);
                        $display("%0t:           actual   ch %02h cp %06h unmapped %0d eol %0d",
                                 $time, got.ch, got.cp, got.unmapped, got.eol);
                        n_errors++;
                    end
                end
                if (got.eol)
                    n_eol++;
                else if (got.unmapped)
                    n_miss++;
                else
                    n_hit++;
            end
            if (s_tvalid && s_tready)
            begin
                moved = 1'b1;
                has_out = decode_map_word(s_tuser, s_tdata, pred);
                if (word_chk == CHK_TYPED)
                    charset_out_q = {charset_out_q, word_typed};
                else if (word_chk == CHK_MODEL && has_out)
                    charset_out_q = {charset_out_q, pred};
            end
            if (cfg_valid && cfg_ready)
            begin
                moved = 1'b1;
                repl_ch = cfg_data;
                n_cfg++;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    initial
    begin
        while (idle_cycles < WD_LIMIT) @(posedge clk);
        $display("%0t: no word moved for %0d cycles", $time, WD_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_word(input logic [1:0] op, input logic [S_TDATA_W-1:0] d,
                             input chk_t chk, input cs_out_t typed);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= d;
        word_chk <= chk;
        word_typed <= typed;
        do @(posedge clk); while (!s_tready);
        n_sent++;
    endtask

    // unused fields carry random bits, but the zero fill stays zero
    task automatic send_op(input logic [1:0] op, input logic [7:0] b);
        logic [S_TDATA_W-1:0] d;
        d[31:0] = $urandom;
        d[47:32] = 16'($urandom);
        d[47:46] = 2'b00;
        d[7:0] = b;
        send_word(op, d, CHK_MODEL, '0);
    endtask

    task automatic send_load(input logic [7:0] idx, input logic [CP_W-1:0] cp,
                             input logic [BYTE_W-1:0] ch, input logic vld);
        send_word(OP_LOAD, {2'b00, vld, ch, cp, idx, 8'($urandom)}, CHK_MODEL, '0);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (charset_out_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_repl(input logic [BYTE_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int n_words);
        int unsigned     pick;
        int              done;
        int              len;
        int              min_len;
        int              pos;
        logic [CP_W-1:0] cp;
        logic [3:0][7:0] seq;
        logic [7:0]      b;
        logic            vld;
        done = 0;
        while (done < n_words)
        begin
            pick = $urandom_range(99);
            if (key_pool.size() != 0 && $urandom_range(1) == 1)
                cp = key_pool[$urandom_range(key_pool.size() - 1)];
            else
                cp = rand_cp();
            min_len = (cp < 'h80) ? 1 : (cp < 'h800) ? 2 : (cp < 'h10000) ? 3 : 4;
            len = min_len;
            if ($urandom_range(3) == 0)
                len = $urandom_range(4, min_len);   // possibly an overlong form
            if ((pick >= 58 && pick < 66) || pick >= 84)
                len = (len < 2) ? 2 : len;
            case (len)
                1: seq[0] = {1'b0, cp[6:0]};
                2:
                begin
                    seq[0] = {3'b110, cp[10:6]};
                    seq[1] = {2'b10, cp[5:0]};
                end
                3:
                begin
                    seq[0] = {4'b1110, cp[15:12]};
                    seq[1] = {2'b10, cp[11:6]};
                    seq[2] = {2'b10, cp[5:0]};
                end
                default:
                begin
                    seq[0] = {5'b11110, cp[20:18]};
                    seq[1] = {2'b10, cp[17:12]};
                    seq[2] = {2'b10, cp[11:6]};
                    seq[3] = {2'b10, cp[5:0]};
                end
            endcase
            if (pick < 66)
            begin
                // from 58 up: one claimed byte is not a continuation
                if (pick >= 58)
                begin
                    pos = $urandom_range(len - 1, 1);
                    b = 8'($urandom);
                    if (b[7:6] == 2'b10)
                        b[6] = 1'b1;
                    seq[pos] = b;
                end
                for (int k = 0; k < len; k++)
                    send_op(OP_TEXT, seq[k]);
                done += len;
            end
            else if (pick < 71)
            begin
                // invalid lead byte, ignored by the block when no sequence is pending
                b = $urandom_range(1) ? 8'($urandom_range(8'hBF, 8'h80))
                                      : 8'($urandom_range(8'hFF, 8'hF8));
                send_op(OP_TEXT, b);
            end
            else if (pick < 84)
            begin
                vld = ($urandom_range(99) < 85);
                if ($urandom_range(2) == 0)
                    cp = CP_W'($urandom);
                send_load($urandom_range(1) ? 8'($urandom_range(31)) : 8'($urandom),
                          cp, 8'($urandom), vld);
                if (vld)
                begin
                    if (key_pool.size() >= POOL_MAX)
                        void'(key_pool.pop_front());
                    key_pool = {key_pool, cp};
                end
                done++;
            end
            else if (pick < 92)
            begin
                // end of line, half the time cutting a sequence short
                if ($urandom_range(1) == 1)
                begin
                    pos = $urandom_range(len - 2);
                    for (int k = 0; k <= pos; k++)
                        send_op(OP_TEXT, seq[k]);
                    done += pos + 1;
                end
                send_op(OP_EOL, 8'($urandom));
                done++;
            end
            else if (pick < 95)
            begin
                send_op(OP_NOP, 8'($urandom));
            end
            else
            begin
                send_op(OP_TEXT, 8'($urandom));
                done++;
            end
        end
    endtask

    initial
    begin
        logic [BYTE_W-1:0] v;
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= OP_TEXT;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        word_chk <= CHK_NONE;
        word_typed <= '0;
        repl_ch = REPL_RESET;
        pend_cnt = 2'd0;
        part_cp = '0;
        seq_bad = 1'b0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            slot_used[i] = 1'b0;
            slot_cp[i] = '0;
            slot_ch[i] = '0;
        end

        // op, text, index, key, byte, valid, check, then expected ch/cp/unmapped/eol
        dir_tbl = '{
            '{OP_TEXT, 8'h41, 8'h00, 21'h0, 8'h00, 1'b0, CHK_TYPED, 8'h3F, 21'h41, 1'b1, 1'b0},
            '{OP_LOAD, 8'h00, 8'h00, 21'h41, 8'hC1, 1'b1, CHK_NONE, 8'h00, 21'h0, 1'b0, 1'b0},
            '{OP_LOAD, 8'h00, 8'hFF, 21'h1FFFFF, 8'hFF, 1'b1, CHK_NONE, 8'h00, 21'h0, 1'b0, 1'b0},
            '{OP_LOAD, 8'h00, 8'h0A, 21'h41, 8'h22, 1'b1, CHK_NONE, 8'h00, 21'h0, 1'b0, 1'b0},
            '{OP_TEXT, 8'h41, 8'h00, 21'h0, 8'h00, 1'b0, CHK_MODEL, 8'h00, 21'h0, 1'b0, 1'b0},
            // largest 4-byte form, hits the last slot
            '{OP_TEXT, 8'hF7, 8'h00, 21'h0, 8'h00, 1'b0, CHK_NONE, 8'h00, 21'h0, 1'b0, 1'b0},
            '{OP_TEXT, 8'hBF, 8'h00, 21'h0, 8'h00, 1'b0, CHK_NONE, 8'h00, 21'h0, 1'b0, 1'b0},
            '{OP_TEXT, 8'hBF, 8'h00, 21'h0, 8'h00, 1'b0, CHK_NONE, 8'h00, 21'h0, 1'b0, 1'b0},
            '{OP_TEXT, 8'hBF, 8'h00, 21'h0, 8'h00, 1'b0, CHK_MODEL, 8'h00, 21'h0, 1'b0, 1'b0},
            '{OP_TEXT, 8'hE2, 8'h00, 21'h0, 8'h00, 1'b0, CHK_NONE, 8'h00, 21'h0, 1'b0, 1'b0},
            '{OP_TEXT, 8'h82, 8'h00, 21'h0, 8'h00, 1'b0, CHK_NONE, 8'h00, 21'h0, 1'b0, 1'b0},
            '{OP_TEXT, 8'hAC, 8'h00, 21'h0, 8'h00, 1'b0, CHK_MODEL, 8'h00, 21'h0, 1'b0, 1'b0},
            // invalid leads
            '{OP_TEXT, 8'h80, 8'h00, 21'h0, 8'h00, 1'b0, CHK_NONE, 8'h00, 21'h0, 1'b0, 1'b0},
            '{OP_TEXT, 8'hF8, 8'h00, 21'h0, 8'h00, 1'b0, CHK_NONE, 8'h00, 21'h0, 1'b0, 1'b0},
            '{OP_TEXT, 8'hFF, 8'h00, 21'h0, 8'h00, 1'b0, CHK_NONE, 8'h00, 21'h0, 1'b0, 1'b0},
            // bad continuation: the claimed byte is swallowed
            '{OP_TEXT, 8'hC3, 8'h00, 21'h0, 8'h00, 1'b0, CHK_NONE, 8'h00, 21'h0, 1'b0, 1'b0},
            '{OP_TEXT, 8'h41, 8'h00, 21'h0, 8'h00, 1'b0, CHK_NONE, 8'h00, 21'h0, 1'b0, 1'b0},
            // truncated by end of line
            '{OP_TEXT, 8'hF0, 8'h00, 21'h0, 8'h00, 1'b0, CHK_NONE, 8'h00, 21'h0, 1'b0, 1'b0},
            '{OP_TEXT, 8'h9F, 8'h00, 21'h0, 8'h00, 1'b0, CHK_NONE, 8'h00, 21'h0, 1'b0, 1'b0},
            '{OP_EOL, 8'h00, 8'h00, 21'h0, 8'h00, 1'b0, CHK_TYPED, 8'h00, 21'h0, 1'b0, 1'b1},
            // clear slot 0, next match is slot 10
            '{OP_LOAD, 8'h00, 8'h00, 21'h41, 8'hC1, 1'b0, CHK_NONE, 8'h00, 21'h0, 1'b0, 1'b0},
            '{OP_TEXT, 8'h41, 8'h00, 21'h0, 8'h00, 1'b0, CHK_MODEL, 8'h00, 21'h0, 1'b0, 1'b0},
            '{OP_NOP, 8'h41, 8'h00, 21'h0, 8'h00, 1'b0, CHK_NONE, 8'h00, 21'h0, 1'b0, 1'b0},
            // load in the middle of a sequence
            '{OP_TEXT, 8'hC3, 8'h00, 21'h0, 8'h00, 1'b0, CHK_NONE, 8'h00, 21'h0, 1'b0, 1'b0},
            '{OP_LOAD, 8'h00, 8'h14, 21'hE9, 8'h82, 1'b1, CHK_NONE, 8'h00, 21'h0, 1'b0, 1'b0},
            '{OP_TEXT, 8'hA9, 8'h00, 21'h0, 8'h00, 1'b0, CHK_MODEL, 8'h00, 21'h0, 1'b0, 1'b0}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_tbl[i])
        begin
            send_word(dir_tbl[i].op,
                      {2'b00, dir_tbl[i].vld, dir_tbl[i].ch, dir_tbl[i].cp,
                       dir_tbl[i].idx, dir_tbl[i].text},
                      dir_tbl[i].chk,
                      {dir_tbl[i].x_ch, dir_tbl[i].x_cp, dir_tbl[i].x_unm, dir_tbl[i].x_eol});
        end

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            wait_idle();
            case (ph)
                0:
                begin
                    v = 8'hFF;
                    tx_idle_pct = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    v = 8'h00;
                    tx_idle_pct = 52;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    v = 8'($urandom);
                    tx_idle_pct = 0;
                    rx_stall_pct = 52;
                end
                3:
                begin
                    v = 8'($urandom);
                    tx_idle_pct = 28;
                    rx_stall_pct = 28;
                end
                default:
                begin
                    v = REPL_RESET;
                    tx_idle_pct = 0;
                    rx_stall_pct = 0;
                end
            endcase
            write_repl(v);
            // long receiver hold-off while the sender keeps offering words
            if (ph == 0)
                hold_req = 1'b1;
            run_random(PHASE_WORDS);
        end

        wait_idle();
        repeat (TABLE_ENTRIES + 16) @(posedge clk);
        if (charset_out_q.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, charset_out_q.size());
            n_errors++;
        end

        $display("Run: %0d words in, %0d table hits, %0d misses, %0d line ends, %0d config writes",
                 n_sent, n_hit, n_miss, n_eol, n_cfg);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
